// ===== rtl/core/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_FIND   = 3'd2,
        OP_GET    = 3'd3,
        OP_UPDATE = 3'd4
    } sle_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } sle_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_WRITE_VAL,
        S_SHIFT_DOWN,
        S_SCAN,
        S_GET
    } sle_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [8:0]  position;
        logic [63:0] value;
    } sle_req_t;

    typedef struct packed {
        sle_status_t status;
        logic [63:0] read_value;
        logic        found;
        logic [7:0]  found_position;
        logic [8:0]  count;
        logic        empty_res;
    } sle_res_t;

endpackage

// ===== rtl/core/sequential_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of 64-bit words in a single-port-read / single-port-write
// store: insert, delete, find, get, update.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------
//  request  | start & !busy             | request (sle_req_t)
//  result   | done, one cycle strobe    | result  (sle_res_t)
//
// Update, out-of-range, full, append, delete of the last entry, find on an
// empty list and unknown opcodes are answered from the idle state; get adds
// one store read in S_GET. Insert inside the list shifts through S_SHIFT_UP
// then S_WRITE_VAL, delete through S_SHIFT_DOWN, find scans in S_SCAN: one
// store access per entry shifted or scanned. Reset clears the entry count
// only; the store is not cleared. The receiver cannot stall; done pulses once per request.
// ----------------------------------------------------------------------------
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  sle_req_t request,
    output logic     busy,
    output logic     done,
    output sle_res_t result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    sle_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    sle_req_t      req_reg, req_next;
    sle_res_t      res_reg, res_next;
    logic          done_reg, done_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;

    logic          respond;
    sle_status_t   rsp_status;
    logic [63:0]   rsp_value;
    logic          rsp_found;
    logic [7:0]    rsp_fpos;

    logic [XW-1:0] pos_in_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cnt_new_x;
    logic [AW-1:0] pos_r_idx;

    assign pos_in_x  = XW'(request.position);
    assign cnt_x     = XW'(count_reg);
    assign cnt_new_x = XW'(count_next);
    assign pos_r_idx = AW'(XW'(req_reg.position));

    sle_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        req_next   = req_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        respond    = 1'b0;
        rsp_status = ST_OK;
        rsp_value  = '0;
        rsp_found  = 1'b0;
        rsp_fpos   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    case (sle_op_t'(request.operation))
                        OP_INSERT:
                        begin
                            if (pos_in_x > cnt_x)
                            begin
                                respond    = 1'b1;
                                rsp_status = ST_RANGE;
                            end
                            else if (cnt_x >= XW'(CAPACITY))
                            begin
                                respond    = 1'b1;
                                rsp_status = ST_FULL;
                            end
                            else if (pos_in_x == cnt_x)
                            begin
                                // append: no shift needed
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = request.value;
                                count_next = count_reg + CW'(1);
                                respond    = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg);
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_in_x >= cnt_x)
                            begin
                                respond    = 1'b1;
                                rsp_status = ST_RANGE;
                            end
                            else if (pos_in_x + XW'(1) == cnt_x)
                            begin
                                count_next = count_reg - CW'(1);
                                respond    = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_in_x + XW'(1));
                                idx_next   = AW'(pos_in_x);
                                state_next = S_SHIFT_DOWN;
                            end
                        end
                        OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                respond = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_GET:
                        begin
                            if (pos_in_x >= cnt_x)
                            begin
                                respond    = 1'b1;
                                rsp_status = ST_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_in_x);
                                state_next = S_GET;
                            end
                        end
                        OP_UPDATE:
                        begin
                            respond = 1'b1;
                            if (pos_in_x >= cnt_x)
                            begin
                                rsp_status = ST_RANGE;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(pos_in_x);
                                wr_data = request.value;
                            end
                        end
                        default:
                        begin
                            respond = 1'b1;
                        end
                    endcase
                end
            end

            // rd_data holds entry idx-1; move it up to idx
            S_SHIFT_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (idx_reg - AW'(1) == pos_r_idx)
                begin
                    state_next = S_WRITE_VAL;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - AW'(2);
                    idx_next = idx_reg - AW'(1);
                end
            end

            S_WRITE_VAL:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_r_idx;
                wr_data    = req_reg.value;
                count_next = count_reg + CW'(1);
                respond    = 1'b1;
                state_next = S_IDLE;
            end

            // rd_data holds entry idx+1; move it down to idx
            S_SHIFT_DOWN:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (CW'(idx_reg) + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    respond    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(2);
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_SCAN:
            begin
                if (rd_data == req_reg.value)
                begin
                    respond    = 1'b1;
                    rsp_found  = 1'b1;
                    rsp_fpos   = 8'(idx_reg);
                    state_next = S_IDLE;
                end
                else if (CW'(idx_reg) + CW'(1) == count_reg)
                begin
                    respond    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_GET:
            begin
                respond    = 1'b1;
                rsp_value  = rd_data;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next  = res_reg;
        done_next = 1'b0;
        if (respond)
        begin
            done_next               = 1'b1;
            res_next.status         = rsp_status;
            res_next.read_value     = rsp_value;
            res_next.found          = rsp_found;
            res_next.found_position = rsp_fpos;
            res_next.count          = cnt_new_x[8:0];
            res_next.empty_res      = (count_next == '0);
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/core/sle_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_store
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_store
    import sle_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
